// ===== rtl/sbsc_pkg.sv =====
// Shared types and constants for the segment/box slab clipper.
// Used by every module of the block but sbsc_fifo; depends on nothing.
package sbsc_pkg;

  localparam int COORD_BITS  = 32;
  localparam int T_FRAC_BITS = 16;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int T_W         = T_FRAC_BITS + 2;
  localparam int OUT_W       = T_FRAC_BITS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [T_W-1:0] T_ZERO = '0;
  localparam logic signed [T_W-1:0] T_ONE  = T_W'(2 ** T_FRAC_BITS);
  localparam logic signed [T_W-1:0] T_SAT  = T_W'(2 ** T_FRAC_BITS + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_coord;
    logic signed [COORD_BITS-1:0] end_coord;
    logic signed [COORD_BITS-1:0] slab_low;
    logic signed [COORD_BITS-1:0] slab_high;
    logic                         final_axis;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] enter_t;
    logic [OUT_W-1:0] leave_t;
  } out_item_t;

  typedef struct packed {
    logic [DIFF_W-1:0] mag_lo;
    logic [DIFF_W-1:0] mag_hi;
    logic [DIFF_W-1:0] mag_d;
    logic              neg_lo;
    logic              neg_hi;
    logic              zero_d;
    logic              in_slab;
    logic              last;
  } work_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPD,
    BK_FIN
  } back_state_e;

endpackage

// ===== rtl/sbsc_fifo.sv =====
// Small first-word-fall-through queue with register storage.
// Generic in depth and item type; depends on nothing else.
module sbsc_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sbsc_front.sv =====
// Front part: forms the exact differences of one axis and classifies it.
// Depends on sbsc_pkg for the item types.
module sbsc_front
  import sbsc_pkg::*;
(
  input  in_item_t   item_i,
  output work_item_t work_o
);

  logic signed [DIFF_W-1:0] s_x, e_x, lo_x, hi_x;
  logic signed [DIFF_W-1:0] d_s, nlo_s, nhi_s;

  always_comb begin
    s_x   = DIFF_W'(item_i.start_coord);
    e_x   = DIFF_W'(item_i.end_coord);
    lo_x  = DIFF_W'(item_i.slab_low);
    hi_x  = DIFF_W'(item_i.slab_high);
    d_s   = e_x - s_x;
    nlo_s = lo_x - s_x;
    nhi_s = hi_x - s_x;

    work_o.mag_d   = d_s[DIFF_W-1] ? DIFF_W'(-d_s) : DIFF_W'(d_s);
    work_o.mag_lo  = nlo_s[DIFF_W-1] ? DIFF_W'(-nlo_s) : DIFF_W'(nlo_s);
    work_o.mag_hi  = nhi_s[DIFF_W-1] ? DIFF_W'(-nhi_s) : DIFF_W'(nhi_s);
    work_o.neg_lo  = nlo_s[DIFF_W-1] ^ d_s[DIFF_W-1];
    work_o.neg_hi  = nhi_s[DIFF_W-1] ^ d_s[DIFF_W-1];
    work_o.zero_d  = (d_s == '0);
    work_o.in_slab = (item_i.slab_low <= item_i.start_coord) &&
                     (item_i.start_coord <= item_i.slab_high);
    work_o.last    = item_i.final_axis;
  end

endmodule

// ===== rtl/sbsc_div.sv =====
// Bit-serial restoring divider giving a saturated slab parameter.
// Depends on sbsc_pkg for widths and the saturation constants.
module sbsc_div
  import sbsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIFF_W-1:0]     num_i,
  input  logic [DIFF_W-1:0]     den_i,
  input  logic                  neg_i,
  output logic                  done_o,
  output logic signed [T_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(T_FRAC_BITS + 1);

  logic [DIFF_W-1:0]      rem_q, dsr_q;
  logic [T_FRAC_BITS:0]   quo_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q, done_q, sat_q, neg_q;
  logic [DIFF_W:0]        x_w, diff_w;
  logic                   ge_w;
  logic [T_W-1:0]         mag_w;

  always_comb begin
    x_w    = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge_w   = (x_w >= {1'b0, dsr_q});
    diff_w = x_w - {1'b0, dsr_q};
  end

  always_comb begin
    if (sat_q || ({1'b0, quo_q} > T_SAT)) begin
      mag_w = T_SAT;
    end else begin
      mag_w = {1'b0, quo_q};
    end
    if (neg_q) begin
      quot_o = (mag_w == '0) ? T_ZERO : -T_W'(1);
    end else begin
      quot_o = signed'(mag_w);
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsr_q <= den_i;
      sat_q <= ({1'b0, num_i} >= {den_i, 1'b0});
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge_w ? diff_w[DIFF_W-1:0] : x_w[DIFF_W-1:0];
      quo_q <= {quo_q[T_FRAC_BITS-1:0], ge_w};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(T_FRAC_BITS)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sbsc_back.sv =====
// Back part: runs both slab divisions, keeps the running entry and exit
// parameters and the reject flag, and forms the result. Uses sbsc_pkg, sbsc_div.
module sbsc_back
  import sbsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  work_item_t work_i,
  input  logic       work_empty_i,
  output logic       work_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output out_item_t  res_o
);

  back_state_e              state_q, state_d;
  work_item_t               cur_q, cur_d;
  logic signed [T_W-1:0]    a_q, a_d, b_q, b_d;
  logic signed [T_W-1:0]    entry_q, entry_d, exit_q, exit_d;
  logic                     rej_q, rej_d;
  logic                     div_start, done_lo, done_hi;
  logic signed [T_W-1:0]    q_lo, q_hi;
  logic signed [T_W-1:0]    p_min, p_max, ent_w, ext_w;
  logic                     hit_w;

  sbsc_div u_div_lo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (work_i.mag_lo),
    .den_i  (work_i.mag_d),
    .neg_i  (work_i.neg_lo),
    .done_o (done_lo),
    .quot_o (q_lo)
  );

  sbsc_div u_div_hi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (work_i.mag_hi),
    .den_i  (work_i.mag_d),
    .neg_i  (work_i.neg_hi),
    .done_o (done_hi),
    .quot_o (q_hi)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!work_empty_i) begin
          state_d = (rej_q || work_i.zero_d) ? BK_UPD : BK_DIV;
        end
      end
      BK_DIV: begin
        if (done_lo && done_hi) begin
          state_d = BK_UPD;
        end
      end
      BK_UPD: begin
        state_d = cur_q.last ? BK_FIN : BK_IDLE;
      end
      BK_FIN: begin
        if (!res_full_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    p_min = (a_q > b_q) ? b_q : a_q;
    p_max = (a_q > b_q) ? a_q : b_q;
    ent_w = (p_min > entry_q) ? p_min : entry_q;
    ext_w = (p_max < exit_q) ? p_max : exit_q;
    hit_w = !rej_q && (exit_q >= T_ZERO) && (entry_q <= T_ONE);
  end

  always_comb begin
    work_pop_o = 1'b0;
    div_start  = 1'b0;
    res_push_o = 1'b0;
    cur_d      = cur_q;
    a_d        = a_q;
    b_d        = b_q;
    entry_d    = entry_q;
    exit_d     = exit_q;
    rej_d      = rej_q;
    res_o      = '0;
    if (hit_w) begin
      res_o.hit     = 1'b1;
      res_o.enter_t = (entry_q < T_ZERO) ? '0 :
                      (entry_q > T_ONE) ? T_ONE[OUT_W-1:0] : entry_q[OUT_W-1:0];
      res_o.leave_t = (exit_q < T_ZERO) ? '0 :
                      (exit_q > T_ONE) ? T_ONE[OUT_W-1:0] : exit_q[OUT_W-1:0];
    end
    unique case (state_q)
      BK_IDLE: begin
        if (!work_empty_i) begin
          work_pop_o = 1'b1;
          cur_d      = work_i;
          div_start  = !(rej_q || work_i.zero_d);
        end
      end
      BK_DIV: begin
        if (done_lo && done_hi) begin
          a_d = q_lo;
          b_d = q_hi;
        end
      end
      BK_UPD: begin
        if (!rej_q) begin
          if (cur_q.zero_d) begin
            rej_d = !cur_q.in_slab;
          end else begin
            entry_d = ent_w;
            exit_d  = ext_w;
            rej_d   = (ent_w > ext_w);
          end
        end
      end
      BK_FIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          entry_d    = T_ZERO;
          exit_d     = T_ONE;
          rej_d      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      entry_q <= T_ZERO;
      exit_q  <= T_ONE;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      entry_q <= entry_d;
      exit_q  <= exit_d;
      rej_q   <= rej_d;
    end
  end

endmodule

// ===== rtl/segment_box_slab_clip.sv =====
// Top level of the segment/box slab clipper: front classifier, work queue,
// back sequencer and result queue. Depends on sbsc_pkg and all sbsc_ modules.
//
// One input transaction carries one axis of a segment-box test; the transaction
// marked as the final axis produces one result transaction (hit flag, entry and
// exit parameters clamped to [0,1] in Q1.16), all others produce none. The back
// part handles one axis at a time: for an axis with a non-zero delta, the two
// bit-serial dividers find the entry and exit quotients side by side, one
// quotient bit per cycle, before the update; an axis with zero delta, or any
// axis after the test has been rejected, skips the dividers and goes straight
// to the update, and the final axis then hands its result over. Queues of
// QUEUE_DEPTH entries on both sides let input and output stall independently.
module segment_box_slab_clip
  import sbsc_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  input  logic      pop,
  output out_item_t out_item_o,
  output logic      empty
);

  work_item_t front_work, work_head;
  logic       work_full, work_empty, work_pop;
  out_item_t  res_data;
  logic       res_full, res_push;

  sbsc_front u_front (
    .item_i(in_item_i),
    .work_o(front_work)
  );

  sbsc_fifo #(
    .DEPTH(QUEUE_DEPTH_P),
    .T    (work_item_t)
  ) u_work_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_work),
    .full_o (work_full),
    .pop_i  (work_pop),
    .data_o (work_head),
    .empty_o(work_empty)
  );

  assign full = work_full;

  sbsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_i      (work_head),
    .work_empty_i(work_empty),
    .work_pop_o  (work_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_data)
  );

  sbsc_fifo #(
    .DEPTH(QUEUE_DEPTH_P),
    .T    (out_item_t)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop |-> !work_empty)
    else $error("Work queue popped while empty.");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.hit) |-> (out_item_o.enter_t == '0 && out_item_o.leave_t == '0))
    else $error("Miss result carries non-zero parameters.");

  a_hit_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.hit) |-> (out_item_o.enter_t <= out_item_o.leave_t))
    else $error("Hit result has entry after exit.");

endmodule
